>>> hdl/rita_pkg.sv
package rita_pkg;

   // Width of one stored digit and of the divisor path
   localparam int DIGIT_W = 4;
   localparam int DIVISOR_W = 5;
   localparam int CHAR_W = 7;
   localparam int RADIX_W = 8;
   localparam int REQ_VALUE_W = 64;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd16;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

   // Status of the shared divider toward the sequencer
   typedef struct packed {
      logic                done;
      logic [DIGIT_W-1:0]  remainder;
   } div_status_type;

   // Map a digit 0..15 to its ASCII glyph
   function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] digit);
      logic [CHAR_W-1:0] glyph;
      if (digit < DIGIT_TEN) begin
         glyph = CHAR_ZERO + {3'b000, digit};
      end else begin
         glyph = CHAR_UPPER_A + {3'b000, digit - DIGIT_TEN};
      end
      return glyph;
   endfunction

endpackage

>>> hdl/rita_divider.sv
module rita_divider import rita_pkg::*; #(
   parameter int VALUE_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_BITS-1:0]  dividend,
   input  logic [DIVISOR_W-1:0]   divisor,
   output logic [VALUE_BITS-1:0]  quotient,
   output div_status_type         status
);

   localparam int STEP_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W-1:0]  trial;
   logic                  fits;

   // Shift one dividend bit into the partial remainder and try the subtract
   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign fits  = (trial >= divisor_ff);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = LAST_STEP;
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? DIGIT_W'(trial - divisor_ff) : DIGIT_W'(trial);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign quotient         = quo_ff;
   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

>>> hdl/rita_digit_store.sv
module rita_digit_store import rita_pkg::*; #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [DIGIT_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [DIGIT_W-1:0] rd_data
);

   logic [DIGIT_W-1:0] mem [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   // Write one remainder, read one registered digit
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/radix_integer_to_ascii.sv
// Iterative radix converter: one shared restoring divider, one quotient bit per cycle.
// An invalid radix is answered in the next cycle. The divider loop sets the rate: one
// request at a time, busy stays high until the last digit is out.
// Digits leave on rsp_valid, each after an ST_READ and an ST_EMIT state; the receiver
// cannot stall.
// Synchronous active-high reset returns the sequencer to idle; the digit store is not cleared.
module radix_integer_to_ascii import rita_pkg::*; #(
   parameter int VALUE_BITS = 64,
   parameter int MAX_DIGITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [REQ_VALUE_W-1:0]  req_value,
   input  logic [RADIX_W-1:0]      req_radix,
   output logic                    rsp_valid,
   output logic [CHAR_W-1:0]       rsp_digit_char,
   output logic                    rsp_last,
   output logic                    rsp_error
);

   localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DIGITS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [DIVISOR_W-1:0]  radix_ff, radix_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_error_ff, rsp_error_in;

   logic                  radix_ok;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic [VALUE_BITS-1:0] div_quotient;
   div_status_type        div_status;
   logic                  store_wr;
   logic [DIGIT_W-1:0]    store_rd_data;

   assign radix_ok = (req_radix >= RADIX_MIN) && (req_radix <= RADIX_MAX);

   rita_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   rita_digit_store #(
      .DEPTH  (MAX_DIGITS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (idx_ff),
      .wr_data (div_status.remainder),
      .rd_addr (idx_ff),
      .rd_data (store_rd_data)
   );

   // Sequence division passes, then read digits back most significant first
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      radix_in     = radix_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      div_divisor  = radix_ff;
      store_wr     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            div_dividend = req_value[VALUE_BITS-1:0];
            div_divisor  = DIVISOR_W'(req_radix);
            if (start) begin
               if (radix_ok) begin
                  div_start = 1'b1;
                  radix_in  = DIVISOR_W'(req_radix);
                  idx_in    = '0;
                  state_in  = ST_DIV;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = '0;
                  rsp_last_in  = 1'b1;
                  rsp_error_in = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               store_wr = 1'b1;
               if ((div_quotient != '0) && (idx_ff != LAST_ADDR)) begin
                  div_start = 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = digit_glyph(store_rd_data);
            rsp_last_in  = (idx_ff == '0);
            rsp_error_in = 1'b0;
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      radix_ff     <= radix_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_error      = rsp_error_ff;

endmodule
